/* sv/second_order_resonator_filter_macros.svh */
// ----------------------------------------------------------------------------
// second_order_resonator_filter_macros
// Assertion macros for the resonator filter; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SECOND_ORDER_RESONATOR_FILTER_MACROS_SVH
`define SECOND_ORDER_RESONATOR_FILTER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define SORF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorf assertion failed");

// next-cycle implication
`define SORF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorf assertion failed");

`else

`define SORF_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define SORF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* sv/sorf_pkg.sv */
// ----------------------------------------------------------------------------
// sorf_pkg
// Types and constants shared by the resonator filter modules.
// ----------------------------------------------------------------------------
package sorf_pkg;

  localparam int COEF_W    = 32;
  localparam int OP_W      = 32;
  localparam int PROD_W    = COEF_W + OP_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int CFG_IDX_W = 3;
  localparam int MODE_W    = 2;

  localparam logic [MODE_W-1:0] MODE_RESONATOR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ANTI       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CONST_GAIN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FB    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_FB   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO        = 3'd4;

  localparam logic [COEF_W-1:0] GAIN_RESET = 32'h0100_0000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [COEF_W-1:0] a;
    logic [COEF_W-1:0] b;
    logic [COEF_W-1:0] c;
    logic [COEF_W-1:0] d;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INNER_MUL1,
    ST_INNER_MUL2,
    ST_INNER_ACC,
    ST_INNER_RND,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_ACC_LAST,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MUL_A_X,
    MUL_A_INNER,
    MUL_B_Y1,
    MUL_C_Y2,
    MUL_B_X1,
    MUL_C_X2,
    MUL_D_X2
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_LOAD_X,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic     load;
    acc_op_t  acc_op;
    mul_sel_t mul_sel;
    logic     inner_rnd;
    logic     fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

/* sv/second_order_resonator_filter.sv */
// resonator mode (and mode 3): y = a*x + b*y1 + c*y2, summed in one accumulator and rounded
// anti-resonator: a*(x - b*x1 - c*x2), no feedback; constant-gain: a*(x + d*x2) + b*y1 + c*y2
// all products go through the single shared 32x32 multiplier, one product per cycle
// a waiting result holds the sequencer in its final step; no new item is taken until it leaves
// synchronous reset clears history, output valid and sequencer; coefficients go to reset values
// ----------------------------------------------------------------------------
// second_order_resonator_filter
// Second-order resonator, anti-resonator and constant-gain resonator, Q8.24.
// ----------------------------------------------------------------------------
`include "second_order_resonator_filter_macros.svh"

module second_order_resonator_filter #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample_in,
  input  logic                           in_channel_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_BITS-1:0]  out_sample_out,
  output logic                           out_clipped,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sorf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sorf_pkg::COEF_W-1:0]    cfg_data
);
  import sorf_pkg::*;

  cfg_regs_t  cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = rst_n;

  sorf_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  sorf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (cfg.mode),
    .status   (status),
    .cmd      (cmd)
  );

  sorf_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg              (cfg),
    .in_sample        (in_sample_in),
    .in_channel_start (in_channel_start),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_sample       (out_sample_out),
    .out_clipped      (out_clipped),
    .status           (status)
  );

  // one item in flight at a time
  `SORF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // a new result only shows up at the end of an item's work
  `SORF_ASSERT_SAME(a_result_from_item, clk, rst_n, $rose(out_valid), $past(!in_ready))

endmodule

/* sv/sorf_regs.sv */
// ----------------------------------------------------------------------------
// sorf_regs
// Configuration register file: filter mode and the four coefficients.
// ----------------------------------------------------------------------------
module sorf_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [sorf_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [sorf_pkg::COEF_W-1:0]    wr_data,
  output sorf_pkg::cfg_regs_t            cfg
);
  import sorf_pkg::*;

  cfg_regs_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_FILTER_MODE: cfg_nxt.mode = wr_data[MODE_W-1:0];
        REG_GAIN:        cfg_nxt.a    = wr_data;
        REG_FIRST_FB:    cfg_nxt.b    = wr_data;
        REG_SECOND_FB:   cfg_nxt.c    = wr_data;
        REG_ZERO:        cfg_nxt.d    = wr_data;
        default:         cfg_nxt      = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= MODE_RESONATOR;
      cfg_r.a    <= GAIN_RESET;
      cfg_r.b    <= '0;
      cfg_r.c    <= '0;
      cfg_r.d    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/sorf_dp.sv */
// ----------------------------------------------------------------------------
// sorf_dp
// Datapath: shared multiplier, accumulator, rounding, history and result.
// ----------------------------------------------------------------------------
module sorf_dp #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sorf_pkg::ctrl_cmd_t           cmd,
  input  sorf_pkg::cfg_regs_t           cfg,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_channel_start,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_clipped,
  output sorf_pkg::dp_status_t          status
);
  import sorf_pkg::*;

  localparam logic signed [ACC_W-1:0] RND_HALF  = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] INNER_MAX = (ACC_W'(1) <<< (OP_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] INNER_MIN = -INNER_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] OUT_MAX   =
    (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] OUT_MIN   = -OUT_MAX - ACC_W'(1);

  logic signed [SAMPLE_BITS-1:0] x_r, x1_r, x2_r, y1_r, y2_r;
  logic signed [SAMPLE_BITS-1:0] x_nxt, x1_nxt, x2_nxt, y1_nxt, y2_nxt;
  logic signed [OP_W-1:0]        inner_r, inner_nxt;
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic                          clip_r, clip_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;
  logic                          out_clip_r, out_clip_nxt;

  logic signed [COEF_W-1:0]      coef_op;
  logic signed [OP_W-1:0]        samp_op;
  logic signed [ACC_W-1:0]       tot, q;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic signed [OP_W-1:0]        inner_sat;
  logic                          inner_clip, y_clip;

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MUL_A_X:     begin coef_op = $signed(cfg.a); samp_op = OP_W'(x_r);  end
      MUL_A_INNER: begin coef_op = $signed(cfg.a); samp_op = inner_r;     end
      MUL_B_Y1:    begin coef_op = $signed(cfg.b); samp_op = OP_W'(y1_r); end
      MUL_C_Y2:    begin coef_op = $signed(cfg.c); samp_op = OP_W'(y2_r); end
      MUL_B_X1:    begin coef_op = $signed(cfg.b); samp_op = OP_W'(x1_r); end
      MUL_C_X2:    begin coef_op = $signed(cfg.c); samp_op = OP_W'(x2_r); end
      MUL_D_X2:    begin coef_op = $signed(cfg.d); samp_op = OP_W'(x2_r); end
      default:     begin coef_op = $signed(cfg.a); samp_op = OP_W'(x_r);  end
    endcase
    prod_nxt = PROD_W'(coef_op) * PROD_W'(samp_op);
  end

  // round half up, then clamp to inner and sample ranges
  always_comb begin
    tot = acc_r + RND_HALF;
    q   = tot >>> COEF_FRAC_BITS;

    inner_clip = 1'b1;
    if (q > INNER_MAX) begin
      inner_sat = INNER_MAX[OP_W-1:0];
    end else if (q < INNER_MIN) begin
      inner_sat = INNER_MIN[OP_W-1:0];
    end else begin
      inner_sat  = q[OP_W-1:0];
      inner_clip = 1'b0;
    end

    y_clip = 1'b1;
    if (q > OUT_MAX) begin
      y_sat = OUT_MAX[SAMPLE_BITS-1:0];
    end else if (q < OUT_MIN) begin
      y_sat = OUT_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat  = q[SAMPLE_BITS-1:0];
      y_clip = 1'b0;
    end
  end

  always_comb begin
    case (cmd.acc_op)
      ACC_CLR:    acc_nxt = '0;
      ACC_LOAD_X: acc_nxt = ACC_W'(in_sample) <<< COEF_FRAC_BITS;
      ACC_ADD:    acc_nxt = acc_r + ACC_W'(prod_r);
      ACC_SUB:    acc_nxt = acc_r - ACC_W'(prod_r);
      default:    acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    x_nxt          = x_r;
    x1_nxt         = x1_r;
    x2_nxt         = x2_r;
    y1_nxt         = y1_r;
    y2_nxt         = y2_r;
    inner_nxt      = inner_r;
    clip_nxt       = clip_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_sample_nxt = out_sample_r;
    out_clip_nxt   = out_clip_r;

    if (cmd.load) begin
      x_nxt    = in_sample;
      clip_nxt = 1'b0;
      if (in_channel_start) begin
        x1_nxt = '0;
        x2_nxt = '0;
        y1_nxt = '0;
        y2_nxt = '0;
      end
    end

    if (cmd.inner_rnd) begin
      inner_nxt = inner_sat;
      clip_nxt  = clip_r | inner_clip;
    end

    if (cmd.fin) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = y_sat;
      out_clip_nxt   = clip_r | y_clip;
      y2_nxt         = y1_r;
      y1_nxt         = y_sat;
      x2_nxt         = x1_r;
      x1_nxt         = x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      x1_r        <= x1_nxt;
      x2_r        <= x2_nxt;
      y1_r        <= y1_nxt;
      y2_r        <= y2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    inner_r      <= inner_nxt;
    prod_r       <= prod_nxt;
    acc_r        <= acc_nxt;
    clip_r       <= clip_nxt;
    out_sample_r <= out_sample_nxt;
    out_clip_r   <= out_clip_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_clipped     = out_clip_r;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

/* sv/sorf_ctrl.sv */
// ----------------------------------------------------------------------------
// sorf_ctrl
// Sequencer: steps one item through the shared multiplier per filter mode.
// ----------------------------------------------------------------------------
module sorf_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sorf_pkg::MODE_W-1:0] mode,
  input  sorf_pkg::dp_status_t        status,
  output sorf_pkg::ctrl_cmd_t         cmd
);
  import sorf_pkg::*;

  state_t state_r, state_nxt;
  logic   is_anti, is_cg, has_inner;

  assign is_anti   = (mode == MODE_ANTI);
  assign is_cg     = (mode == MODE_CONST_GAIN);
  assign has_inner = is_anti || is_cg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.acc_op    = ACC_HOLD;
    cmd.mul_sel   = MUL_A_X;
    cmd.inner_rnd = 1'b0;
    cmd.fin       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load   = 1'b1;
          cmd.acc_op = has_inner ? ACC_LOAD_X : ACC_CLR;
          state_nxt  = has_inner ? ST_INNER_MUL1 : ST_MUL_A;
        end
      end
      ST_INNER_MUL1: begin
        cmd.mul_sel = is_anti ? MUL_B_X1 : MUL_D_X2;
        state_nxt   = is_anti ? ST_INNER_MUL2 : ST_INNER_ACC;
      end
      ST_INNER_MUL2: begin
        cmd.mul_sel = MUL_C_X2;
        cmd.acc_op  = ACC_SUB;
        state_nxt   = ST_INNER_ACC;
      end
      ST_INNER_ACC: begin
        cmd.acc_op = is_anti ? ACC_SUB : ACC_ADD;
        state_nxt  = ST_INNER_RND;
      end
      ST_INNER_RND: begin
        cmd.inner_rnd = 1'b1;
        cmd.acc_op    = ACC_CLR;
        state_nxt     = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.mul_sel = has_inner ? MUL_A_INNER : MUL_A_X;
        // anti-resonator has no output feedback
        state_nxt   = is_anti ? ST_ACC_LAST : ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.mul_sel = MUL_B_Y1;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = ST_MUL_C;
      end
      ST_MUL_C: begin
        cmd.mul_sel = MUL_C_Y2;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = ST_ACC_LAST;
      end
      ST_ACC_LAST: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
